FILE: rtl/core/ols_pkg.sv
// Shared types and constants for the ordered list store.
package ols_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_ABSENT  = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [CNT_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/core/ols_store.sv
// Entry storage: one write port, one read port with registered read data.
module ols_store
  import ols_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/ordered_list_store.sv
// Top level: request sequencer of the ordered list store.
//
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_strobe high (the receiver cannot stall
// it). Items that are settled at once (bad position, full store, query or
// remove on an empty store, insert or append at the end) give their result
// in the cycle after start and leave busy low. An insert at position p walks
// the store (one write port, one read port) with one entry move per cycle.
// Query and remove scan the store one entry per cycle from the front (one
// compare unit on the registered read data); remove then moves each later
// entry down one per cycle.
module ordered_list_store
  import ols_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_SRCH,
    S_RM_SHIFT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [1:0]              op_r, op_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    out_vld_r, out_vld_nxt;
  out_t                    out_r, out_nxt;
  logic [1:0]              stat_nxt;
  mem_req_t                req;
  logic [VAL_W-1:0]        rd_data;
  logic                    hit;
  logic [CNT_W-1:0]        p_sel;

  ols_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // shared compare unit
  assign hit = (rd_data == val_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    out_vld_nxt = 1'b0;
    stat_nxt    = STAT_OK;
    req         = '0;
    p_sel       = (in_item.op == OP_APPEND) ? count_r : in_item.position;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_item.op;
          val_nxt = in_item.value;
          case (in_item.op) inside
            OP_APPEND, OP_INSERT: begin
              pos_nxt = p_sel;
              if (p_sel > count_r) begin
                out_vld_nxt = 1'b1;
                stat_nxt    = STAT_BAD_POS;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                out_vld_nxt = 1'b1;
                stat_nxt    = STAT_FULL;
              end else if (p_sel == count_r) begin
                req.we      = 1'b1;
                req.waddr   = p_sel[IDX_W-1:0];
                req.wdata   = in_item.value;
                count_nxt   = count_r + CNT_W'(1);
                out_vld_nxt = 1'b1;
              end else begin
                // prefetch the last entry, then move entries up from the end
                req.raddr = IDX_W'(count_r - CNT_W'(1));
                idx_nxt   = count_r[IDX_W-1:0];
                state_nxt = S_INS_SHIFT;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_vld_nxt = 1'b1;
                stat_nxt    = STAT_ABSENT;
              end else begin
                req.raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        req.we    = 1'b1;
        req.waddr = idx_r;
        req.wdata = rd_data;
        if ((idx_r - IDX_W'(1)) == pos_r[IDX_W-1:0]) begin
          state_nxt = S_INS_PUT;
        end else begin
          req.raddr = idx_r - IDX_W'(2);
          idx_nxt   = idx_r - IDX_W'(1);
        end
      end

      S_INS_PUT: begin
        req.we      = 1'b1;
        req.waddr   = pos_r[IDX_W-1:0];
        req.wdata   = val_r;
        count_nxt   = count_r + CNT_W'(1);
        out_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end

      S_SRCH: begin
        // read data holds entry idx_r; next entry is fetched meanwhile
        req.raddr = idx_r + IDX_W'(1);
        if (hit) begin
          if (op_r == OP_QUERY) begin
            out_vld_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
            count_nxt   = count_r - CNT_W'(1);
            out_vld_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_RM_SHIFT;
          end
        end else if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          out_vld_nxt = 1'b1;
          stat_nxt    = STAT_ABSENT;
          state_nxt   = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_RM_SHIFT: begin
        req.we    = 1'b1;
        req.waddr = idx_r;
        req.wdata = rd_data;
        req.raddr = idx_r + IDX_W'(2);
        if (CNT_W'(idx_r) + CNT_W'(2) == count_r) begin
          count_nxt   = count_r - CNT_W'(1);
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt = out_r;
    if (out_vld_nxt) begin
      out_nxt.status = stat_nxt;
      out_nxt.count  = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
    idx_r <= idx_nxt;
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_vld_r;
  assign out_item   = out_r;

endmodule
